/* design/gmds_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the grid maze depth-first solver
// no dependencies

package gmds_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_SOLVE = 2'd2
    } gmds_cmd_t;

    localparam logic [1:0] KIND_BLOCKED = 2'd0;
    localparam logic [1:0] KIND_OPEN    = 2'd1;
    localparam logic [1:0] KIND_GOAL    = 2'd2;
    localparam logic [1:0] KIND_PATH    = 2'd3;

    localparam logic [2:0] ADDR_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_GRID_HEIGHT = 3'd4;

    localparam int SIDE_REG_W = 6;
    localparam int SIDE_W     = 7;
    localparam int CELL_W     = 3;
    localparam int DIR_W      = 3;
    localparam logic [DIR_W-1:0] DIR_DONE = 3'd4;

    typedef struct packed {
        gmds_cmd_t  cmd;
        logic [4:0] row;
        logic [4:0] col;
        logic [1:0] cell_kind;
    } gmds_in_t;

    typedef struct packed {
        logic [1:0] read_kind;
        logic       found;
        logic [9:0] steps;
    } gmds_out_t;

endpackage

/* design/gmds_ram.sv */
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module gmds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/grid_maze_dfs_solver_core.sv */
`timescale 1ns / 1ps
// grid maze depth-first solver top level: command sequencer, search, apb registers
// depends on gmds_pkg and gmds_ram
//
// usage:
// commands arrive on cmd_valid / cmd_ready / cmd_data, one result per command
// leaves on rsp_valid / rsp_ready / rsp_data through an output register.
// write cell: the cell is written as the command is taken. read cell: the
// cell memory read is registered, then the kind is captured in S_READ.
// solve: a read-modify-write sweep of the cell memory clears the visited
// marks, then the search tries each direction, backtracks from dead ends and
// marks the path cells. one command is worked on at a time.
// cmd_ready is high while the sequencer is idle; a command may be taken while
// the previous result still waits in the output register.
// if the receiver stalls, the finished result waits in the sequencer until the
// output register frees up.
// after reset a clearing pass writes every cell blocked, one per cycle
// with cmd_ready low; register writes are taken.
// grid_width at byte 0, grid_height at byte 4; values above MAX_SIDE act as MAX_SIDE.

module grid_maze_dfs_solver_core
    import gmds_pkg::*;
#(
    parameter int MAX_SIDE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  gmds_in_t    cmd_data,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output gmds_out_t   rsp_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW     = $clog2(MAX_SIDE);
    localparam int CELL_N = MAX_SIDE * MAX_SIDE;
    localparam int AW     = $clog2(CELL_N);
    localparam int TW     = $clog2(CELL_N + 1);
    localparam int SWD    = 2 * CW + DIR_W;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_CHECK,
        S_START,
        S_DIR,
        S_NB,
        S_POP,
        S_MARK_RD,
        S_MARK_WR,
        S_DONE
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                                 input logic [CW-1:0] c);
        cell_addr = AW'(32'(r) * MAX_SIDE + 32'(c));
    endfunction

    state_t            state_reg, state_next;
    logic [TW-1:0]     cnt_reg, cnt_next;
    logic [TW-1:0]     top_reg, top_next;
    logic [CW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [DIR_W-1:0]  dir_reg, dir_next;
    logic [CW-1:0]     cand_row_reg, cand_row_next;
    logic [CW-1:0]     cand_col_reg, cand_col_next;
    gmds_in_t          in_reg, in_next;
    gmds_out_t         res_reg, res_next;
    gmds_out_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [SIDE_REG_W-1:0] width_reg, height_reg;

    logic              c_we;
    logic [AW-1:0]     c_waddr, c_raddr;
    logic [CELL_W-1:0] c_wdata, c_rdata;
    logic              s_we;
    logic [AW-1:0]     s_waddr, s_raddr;
    logic [SWD-1:0]    s_wdata, s_rdata;

    logic [SIDE_W-1:0] width_eff, height_eff;
    logic              nb_ok;
    logic [CW-1:0]     nb_row, nb_col;
    logic              in_inside, reg_inside, start_ok, enter;

    gmds_ram #(.WIDTH(CELL_W), .DEPTH(CELL_N)) u_cells (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    gmds_ram #(.WIDTH(SWD), .DEPTH(CELL_N)) u_stack (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // apb registers
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr)
            ADDR_GRID_WIDTH:  prdata = 32'(width_reg);
            ADDR_GRID_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIDE_REG_W'(20);
            height_reg <= SIDE_REG_W'(20);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == ADDR_GRID_WIDTH)
            begin
                width_reg <= pwdata[SIDE_REG_W-1:0];
            end
            if (paddr == ADDR_GRID_HEIGHT)
            begin
                height_reg <= pwdata[SIDE_REG_W-1:0];
            end
        end
    end

    assign width_eff  = (SIDE_W'(width_reg) > SIDE_W'(MAX_SIDE)) ?
                        SIDE_W'(MAX_SIDE) : SIDE_W'(width_reg);
    assign height_eff = (SIDE_W'(height_reg) > SIDE_W'(MAX_SIDE)) ?
                        SIDE_W'(MAX_SIDE) : SIDE_W'(height_reg);

    assign in_inside  = (SIDE_W'(cmd_data.row) < SIDE_W'(MAX_SIDE)) &&
                        (SIDE_W'(cmd_data.col) < SIDE_W'(MAX_SIDE));
    assign reg_inside = (SIDE_W'(in_reg.row) < SIDE_W'(MAX_SIDE)) &&
                        (SIDE_W'(in_reg.col) < SIDE_W'(MAX_SIDE));
    assign start_ok   = (SIDE_W'(in_reg.row) < height_eff) &&
                        (SIDE_W'(in_reg.col) < width_eff);

    // neighbor in the current direction
    always_comb
    begin
        nb_row = row_reg;
        nb_col = col_reg;
        nb_ok  = 1'b0;
        case (dir_reg[1:0])
            2'd0:
            begin
                nb_ok  = (SIDE_W'(col_reg) + SIDE_W'(1)) < width_eff;
                nb_col = col_reg + CW'(1);
            end
            2'd1:
            begin
                nb_ok  = (SIDE_W'(row_reg) + SIDE_W'(1)) < height_eff;
                nb_row = row_reg + CW'(1);
            end
            2'd2:
            begin
                nb_ok  = row_reg != '0;
                nb_row = row_reg - CW'(1);
            end
            default:
            begin
                nb_ok  = col_reg != '0;
                nb_col = col_reg - CW'(1);
            end
        endcase
    end

    assign enter = !c_rdata[2] &&
                   (c_rdata[1:0] == KIND_OPEN || c_rdata[1:0] == KIND_GOAL) &&
                   (top_reg < TW'(CELL_N));

    assign cmd_ready = state_reg == S_IDLE;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        top_next       = top_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        dir_next       = dir_reg;
        cand_row_next  = cand_row_reg;
        cand_col_next  = cand_col_reg;
        in_next        = in_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        c_we           = 1'b0;
        c_waddr        = '0;
        c_wdata        = '0;
        c_raddr        = '0;
        s_we           = 1'b0;
        s_waddr        = '0;
        s_wdata        = '0;
        s_raddr        = '0;

        unique case (state_reg)
            S_INIT:
            begin
                c_we     = 1'b1;
                c_waddr  = cnt_reg[AW-1:0];
                cnt_next = cnt_reg + TW'(1);
                if (cnt_reg == TW'(CELL_N - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    in_next  = cmd_data;
                    res_next = '0;
                    case (cmd_data.cmd)
                        CMD_WRITE:
                        begin
                            c_we       = in_inside;
                            c_waddr    = cell_addr(CW'(cmd_data.row), CW'(cmd_data.col));
                            c_wdata    = {1'b0, cmd_data.cell_kind};
                            state_next = S_DONE;
                        end
                        CMD_READ:
                        begin
                            c_raddr    = cell_addr(CW'(cmd_data.row), CW'(cmd_data.col));
                            state_next = S_READ;
                        end
                        CMD_SOLVE:
                        begin
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_next.read_kind = reg_inside ? c_rdata[1:0] : KIND_BLOCKED;
                state_next         = S_DONE;
            end
            S_CLEAR:
            begin
                // read entry n while writing back entry n-1 with visited cleared
                if (cnt_reg < TW'(CELL_N))
                begin
                    c_raddr = cnt_reg[AW-1:0];
                end
                if (cnt_reg != '0)
                begin
                    c_we    = 1'b1;
                    c_waddr = AW'(cnt_reg - TW'(1));
                    c_wdata = {1'b0, c_rdata[1:0]};
                end
                cnt_next = cnt_reg + TW'(1);
                if (cnt_reg == TW'(CELL_N))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                top_next = '0;
                row_next = CW'(in_reg.row);
                col_next = CW'(in_reg.col);
                c_raddr  = cell_addr(CW'(in_reg.row), CW'(in_reg.col));
                if (start_ok)
                begin
                    state_next = S_START;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_START:
            begin
                c_we     = 1'b1;
                c_waddr  = cell_addr(row_reg, col_reg);
                c_wdata  = {1'b1, c_rdata[1:0]};
                dir_next = '0;
                top_next = TW'(1);
                if (c_rdata[1:0] == KIND_GOAL)
                begin
                    res_next.found = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                if (dir_reg == DIR_DONE)
                begin
                    top_next = top_reg - TW'(1);
                    if (top_reg == TW'(1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        s_raddr    = AW'(top_reg - TW'(2));
                        state_next = S_POP;
                    end
                end
                else
                begin
                    dir_next      = dir_reg + DIR_W'(1);
                    cand_row_next = nb_row;
                    cand_col_next = nb_col;
                    if (nb_ok)
                    begin
                        c_raddr    = cell_addr(nb_row, nb_col);
                        state_next = S_NB;
                    end
                end
            end
            S_NB:
            begin
                state_next = S_DIR;
                if (enter)
                begin
                    c_we     = 1'b1;
                    c_waddr  = cell_addr(cand_row_reg, cand_col_reg);
                    c_wdata  = {1'b1, c_rdata[1:0]};
                    s_we     = 1'b1;
                    s_waddr  = AW'(top_reg - TW'(1));
                    s_wdata  = {row_reg, col_reg, dir_reg};
                    row_next = cand_row_reg;
                    col_next = cand_col_reg;
                    dir_next = '0;
                    top_next = top_reg + TW'(1);
                    if (c_rdata[1:0] == KIND_GOAL)
                    begin
                        cnt_next   = TW'(1);
                        state_next = S_MARK_RD;
                    end
                end
            end
            S_POP:
            begin
                row_next   = s_rdata[SWD-1 -: CW];
                col_next   = s_rdata[DIR_W+CW-1 -: CW];
                dir_next   = s_rdata[DIR_W-1:0];
                state_next = S_DIR;
            end
            S_MARK_RD:
            begin
                if (cnt_reg + TW'(1) < top_reg)
                begin
                    s_raddr    = cnt_reg[AW-1:0];
                    state_next = S_MARK_WR;
                end
                else
                begin
                    res_next.found = 1'b1;
                    res_next.steps = 10'(top_reg - TW'(1));
                    state_next     = S_DONE;
                end
            end
            S_MARK_WR:
            begin
                c_we       = 1'b1;
                c_waddr    = cell_addr(s_rdata[SWD-1 -: CW], s_rdata[DIR_W+CW-1 -: CW]);
                c_wdata    = {1'b1, KIND_PATH};
                cnt_next   = cnt_reg + TW'(1);
                state_next = S_MARK_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        dir_reg      <= dir_next;
        cand_row_reg <= cand_row_next;
        cand_col_reg <= cand_col_next;
        in_reg       <= in_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TW'(CELL_N))
        else $error("search stack depth beyond cell count");

    a_dir_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIR || state_reg == S_NB) |-> top_reg != '0)
        else $error("search step with empty stack");

    a_nb_after_dir: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_NB |-> $past(state_reg) == S_DIR)
        else $error("neighbor check without issued read");

    a_found_no_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.found) |-> rsp_data.read_kind == KIND_BLOCKED)
        else $error("solve result carries a read kind");
`endif

endmodule
